### sv/ssltab_pkg.sv
// ----------------------------------------------------------------------------
// Successor slot table package
// Shared widths, codes and types of the successor slot table.
// ----------------------------------------------------------------------------
package ssltab_pkg;

  localparam int SLOTS       = 2;
  localparam int COUNT_BITS  = 32;
  localparam int IDX_W       = $clog2(SLOTS);
  localparam int KIND_W      = 2;
  localparam int ADDR_W      = 64;
  localparam int HANDLE_W    = 16;
  localparam int STATUS_W    = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_INSERTED = 3'd2,
    ST_FULL     = 3'd3,
    ST_REMOVED  = 3'd4
  } status_t;

  typedef struct packed {
    logic                  used;
    logic [ADDR_W-1:0]     address;
    logic [HANDLE_W-1:0]   handle;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

  typedef struct packed {
    logic             a_en;
    logic [IDX_W-1:0] a_idx;
    entry_t           a_data;
    logic             b_en;
    logic [IDX_W-1:0] b_idx;
    entry_t           b_data;
  } wr_cmd_t;

endpackage

### sv/ssltab_if.sv
// ----------------------------------------------------------------------------
// Successor slot table channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ssltab_req_if;
  logic                               valid;
  logic                               ready;
  logic [ssltab_pkg::KIND_W-1:0]      kind;
  logic [ssltab_pkg::ADDR_W-1:0]      address;
  logic [ssltab_pkg::HANDLE_W-1:0]    handle;

  modport source (output valid, output kind, output address, output handle, input ready);
  modport sink   (input valid, input kind, input address, input handle, output ready);
endinterface

interface ssltab_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [ssltab_pkg::STATUS_W-1:0]    status;
  logic [ssltab_pkg::HANDLE_W-1:0]    found_handle;

  modport source (output valid, output status, output found_handle, input ready);
  modport sink   (input valid, input status, input found_handle, output ready);
endinterface

### sv/successor_slot_table_unit.sv
// ----------------------------------------------------------------------------
// Successor slot table unit
// Count-and-transpose table of successor slots with lookup, insert, remove.
// ----------------------------------------------------------------------------
// Each request word is scanned one slot per cycle from slot 0 through a
// single shared address comparator and count incrementer. A request passes
// through an accept state (S_IDLE), a scan (S_SCAN) that stops at the slot
// that settles it (a remove always scans all SLOTS slots), and a hold state
// (S_HOLD) that hands the response word to the output register once it is
// free. The request channel is ready only while the unit is idle, and the
// output register holds a finished response word until it is taken.
module successor_slot_table_unit (
  input  logic          clk,
  input  logic          rst,
  ssltab_req_if.sink    req,
  ssltab_rsp_if.source  rsp
);

  logic [ssltab_pkg::IDX_W-1:0] rd_idx;
  ssltab_pkg::entry_t           rd_entry;
  ssltab_pkg::wr_cmd_t          wr;

  ssltab_store u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry),
    .wr       (wr)
  );

  ssltab_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry),
    .wr       (wr)
  );

endmodule

### sv/ssltab_store.sv
// ----------------------------------------------------------------------------
// Successor slot storage
// Slot registers with one indexed read port and two write ports for swaps.
// ----------------------------------------------------------------------------
module ssltab_store (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [ssltab_pkg::IDX_W-1:0] rd_idx,
  output ssltab_pkg::entry_t           rd_entry,
  input  ssltab_pkg::wr_cmd_t          wr
);

  ssltab_pkg::entry_t slots [ssltab_pkg::SLOTS];
  logic [ssltab_pkg::SLOTS-1:0] used;

  always_comb begin
    rd_entry      = slots[rd_idx];
    rd_entry.used = used[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (wr.a_en) begin
      slots[wr.a_idx] <= wr.a_data;
    end
    if (wr.b_en) begin
      slots[wr.b_idx] <= wr.b_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      if (wr.a_en) begin
        used[wr.a_idx] <= wr.a_data.used;
      end
      if (wr.b_en) begin
        used[wr.b_idx] <= wr.b_data.used;
      end
    end
  end

endmodule

### sv/ssltab_ctrl.sv
// ----------------------------------------------------------------------------
// Successor slot table sequencer
// Scans one slot per cycle through a shared address compare and count unit.
// ----------------------------------------------------------------------------
module ssltab_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  ssltab_req_if.sink                   req,
  ssltab_rsp_if.source                 rsp,
  output logic [ssltab_pkg::IDX_W-1:0] rd_idx,
  input  ssltab_pkg::entry_t           rd_entry,
  output ssltab_pkg::wr_cmd_t          wr
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t state, state_next;

  logic [ssltab_pkg::KIND_W-1:0]     kind;
  logic [ssltab_pkg::ADDR_W-1:0]     address;
  logic [ssltab_pkg::HANDLE_W-1:0]   handle;
  logic [ssltab_pkg::IDX_W-1:0]      idx, idx_next;
  ssltab_pkg::entry_t                prev, prev_next;
  logic [ssltab_pkg::STATUS_W-1:0]   res_status, res_status_next;
  logic [ssltab_pkg::HANDLE_W-1:0]   res_found, res_found_next;
  logic                              out_valid;
  logic [ssltab_pkg::STATUS_W-1:0]   out_status;
  logic [ssltab_pkg::HANDLE_W-1:0]   out_found;

  logic                              match;
  logic                              last;
  logic                              promote;
  logic [ssltab_pkg::COUNT_BITS-1:0] cnt_inc;
  logic                              finish;
  logic                              out_free;

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.found_handle = out_found;
  assign rd_idx           = idx;
  assign out_free         = !out_valid || rsp.ready;

  assign match   = rd_entry.used && (rd_entry.address == address);
  assign last    = (idx == ssltab_pkg::IDX_W'(ssltab_pkg::SLOTS - 1));
  assign cnt_inc = (rd_entry.count == '1) ? rd_entry.count
                                          : rd_entry.count + ssltab_pkg::COUNT_BITS'(1);
  assign promote = (idx != '0) && (cnt_inc > prev.count);

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    prev_next       = prev;
    res_status_next = res_status;
    res_found_next  = res_found;
    finish          = 1'b0;
    wr              = '0;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_SCAN;
          idx_next   = '0;
        end
      end
      S_SCAN: begin
        res_found_next = '0;
        case (kind)
          ssltab_pkg::KIND_LOOKUP: begin
            if (!rd_entry.used) begin
              finish          = 1'b1;
              res_status_next = ssltab_pkg::ST_MISS;
            end else if (match) begin
              finish          = 1'b1;
              res_status_next = ssltab_pkg::ST_HIT;
              res_found_next  = rd_entry.handle;
              wr.a_en         = 1'b1;
              if (promote) begin
                wr.a_idx          = idx - ssltab_pkg::IDX_W'(1);
                wr.a_data         = rd_entry;
                wr.a_data.count   = cnt_inc;
                wr.b_en           = 1'b1;
                wr.b_idx          = idx;
                wr.b_data         = prev;
              end else begin
                wr.a_idx          = idx;
                wr.a_data         = rd_entry;
                wr.a_data.count   = cnt_inc;
              end
            end else if (last) begin
              finish          = 1'b1;
              res_status_next = ssltab_pkg::ST_MISS;
            end
          end
          ssltab_pkg::KIND_INSERT: begin
            if (!rd_entry.used) begin
              finish                = 1'b1;
              res_status_next       = ssltab_pkg::ST_INSERTED;
              wr.a_en               = 1'b1;
              wr.a_idx              = idx;
              wr.a_data.used        = 1'b1;
              wr.a_data.address     = address;
              wr.a_data.handle      = handle;
              wr.a_data.count       = ssltab_pkg::COUNT_BITS'(1);
            end else if (last) begin
              finish          = 1'b1;
              res_status_next = ssltab_pkg::ST_FULL;
            end
          end
          ssltab_pkg::KIND_REMOVE: begin
            if (match) begin
              wr.a_en  = 1'b1;
              wr.a_idx = idx;
            end
            if (last) begin
              finish          = 1'b1;
              res_status_next = ssltab_pkg::ST_REMOVED;
            end
          end
          default: begin
            finish          = 1'b1;
            res_status_next = ssltab_pkg::ST_MISS;
          end
        endcase
        if (finish) begin
          state_next = S_HOLD;
        end else begin
          idx_next  = idx + ssltab_pkg::IDX_W'(1);
          prev_next = rd_entry;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_HOLD && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    prev       <= prev_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
    if (state == S_IDLE && req.valid) begin
      kind    <= req.kind;
      address <= req.address;
      handle  <= req.handle;
    end
    if (state == S_HOLD && out_free) begin
      out_status <= res_status;
      out_found  <= res_found;
    end
  end

endmodule
